// ===== rtl/hcfp_pkg.sv =====
// Shared types, codes and sizes for the host command frame parser.
package hcfp_pkg;

	// Default buffer sizes; usable capacity is two less than each
	localparam int NameBufLenDef = 8;
	localparam int ArgBufLenDef  = 64;

	// Queue depths between the stages
	localparam int CmdqDepth = 2;
	localparam int ResqDepth = 4;

	// Letters shown on the command text output
	localparam int TextChars = 6;
	localparam int TextW     = 8 * TextChars;

	// Action codes
	localparam logic [1:0] ACT_RX      = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	// Framing characters
	localparam logic [7:0] CH_START   = 8'h21;
	localparam logic [7:0] CH_SEP     = 8'h23;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_LF      = 8'h0A;

	typedef enum logic [1:0] {
		KIND_RX,
		KIND_READ,
		KIND_RELEASE,
		KIND_NOP
	} kind_t;

	typedef enum logic [2:0] {
		CLS_START,
		CLS_LETTER,
		CLS_SEP,
		CLS_EOL,
		CLS_OTHER
	} cls_t;

	// Classified command handed from front to back
	typedef struct packed {
		kind_t       kind;
		cls_t        cls;
		logic [7:0]  data;
		logic [5:0]  index;
	} cmd_t;

	// One result transfer
	typedef struct packed {
		logic              frame_ready;
		logic [TextW-1:0]  command_text;
		logic [2:0]        command_length;
		logic [5:0]        param_length;
		logic [7:0]        read_data;
	} res_t;

endpackage

// ===== rtl/hcfp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hcfp_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 62,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/hcfp_fifo.sv =====
// Small register-based FIFO with fill level (DEPTH of 2 or more).
module hcfp_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2,
	localparam int PW   = $clog2(DEPTH),
	localparam int LW   = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  din,
	output logic          full,
	input  logic          pop,
	output logic [W-1:0]  dout,
	output logic          empty,
	output logic [LW-1:0] level
);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign dout    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// ===== rtl/hcfp_front.sv =====
// Front end: decodes action and byte class, queues commands for the back end.
module hcfp_front
	import hcfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] action,
	input  logic [7:0] rx_byte,
	input  logic [5:0] read_index,
	input  logic       cmd_pop,
	output logic       cmd_empty,
	output cmd_t       cmd
);

	localparam int CLW = $clog2(CmdqDepth + 1);

	cmd_t           cmd_in;
	logic [CLW-1:0] cmd_level;

	always_comb begin
		cmd_in.data  = rx_byte;
		cmd_in.index = read_index;
		unique case (action)
			ACT_RX:      cmd_in.kind = KIND_RX;
			ACT_READ:    cmd_in.kind = KIND_READ;
			ACT_RELEASE: cmd_in.kind = KIND_RELEASE;
			default:     cmd_in.kind = KIND_NOP;
		endcase
		unique case (rx_byte) inside
			CH_START:                 cmd_in.cls = CLS_START;
			CH_SEP:                   cmd_in.cls = CLS_SEP;
			CH_CR, CH_LF:             cmd_in.cls = CLS_EOL;
			[CH_UPPER_A:CH_UPPER_Z]:  cmd_in.cls = CLS_LETTER;
			default:                  cmd_in.cls = CLS_OTHER;
		endcase
	end

	hcfp_fifo #(
		.W     ($bits(cmd_t)),
		.DEPTH (CmdqDepth)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.din   (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.dout  (cmd),
		.empty (cmd_empty),
		.level (cmd_level)
	);

	// level is not used here
	logic unused_level;
	assign unused_level = ^cmd_level;

endmodule

// ===== rtl/hcfp_back.sv =====
// Back end: frame parser state, name and parameter stores, result build.
module hcfp_back
	import hcfp_pkg::*;
#(
	parameter int NAME_BUF_LEN = NameBufLenDef,
	parameter int ARG_BUF_LEN  = ArgBufLenDef,
	localparam int RLW         = $clog2(ResqDepth + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_empty,
	input  cmd_t           cmd,
	output logic           cmd_pop,
	input  logic [RLW-1:0] res_level,
	output logic           res_push,
	output res_t           res
);

	localparam int NameCap = NAME_BUF_LEN - 2;
	localparam int ArgCap  = ARG_BUF_LEN - 2;
	localparam int NCW     = $clog2(NameCap + 1);
	localparam int ACW     = $clog2(ArgCap + 1);
	localparam int AAW     = $clog2(ArgCap);
	localparam int IXW     = (ACW > 6) ? ACW : 6;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_NAME,
		PH_PARAMS
	} phase_t;

	phase_t          phase_q;
	logic            pending_q;
	logic [NCW-1:0]  name_cnt_q;
	logic [ACW-1:0]  arg_cnt_q;
	logic [7:0]      name_q [NameCap];
	logic            valid_s2;
	logic            rd_hit_s2;

	logic            is_rx;
	logic            name_wr;
	logic            arg_wr;
	logic            rd_hit;
	logic [IXW-1:0]  idx_w;
	logic [RLW:0]    occupancy;
	logic [7:0]      ram_rdata;
	logic [NCW+2:0]  name_cnt_ext;
	logic [ACW+5:0]  arg_cnt_ext;

	// Issue only with a result slot guaranteed, counting the one in flight
	assign occupancy = (RLW + 1)'(res_level) + (RLW + 1)'(valid_s2);
	assign cmd_pop   = !cmd_empty && (occupancy < (RLW + 1)'(ResqDepth));

	assign is_rx   = cmd_pop && (cmd.kind == KIND_RX);
	assign name_wr = is_rx && (phase_q == PH_NAME) && (cmd.cls == CLS_LETTER)
		&& (name_cnt_q < NCW'(NameCap));
	assign arg_wr  = is_rx && (phase_q == PH_PARAMS) && (cmd.cls != CLS_EOL)
		&& (arg_cnt_q < ACW'(ArgCap));

	assign idx_w  = IXW'(cmd.index);
	assign rd_hit = (cmd.kind == KIND_READ) && (idx_w < IXW'(arg_cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pending_q  <= 1'b0;
			name_cnt_q <= '0;
			arg_cnt_q  <= '0;
			valid_s2   <= 1'b0;
			rd_hit_s2  <= 1'b0;
		end else begin
			valid_s2 <= cmd_pop;
			if (cmd_pop) begin
				rd_hit_s2 <= rd_hit;
			end
			if (cmd_pop && (cmd.kind == KIND_RELEASE)) begin
				pending_q <= 1'b0;
			end
			if (is_rx) begin
				unique case (phase_q)
					PH_IDLE: begin
						if ((cmd.cls == CLS_START) && !pending_q) begin
							phase_q    <= PH_NAME;
							name_cnt_q <= '0;
							arg_cnt_q  <= '0;
						end
					end
					PH_NAME: begin
						if (cmd.cls == CLS_LETTER) begin
							if (name_wr) begin
								name_cnt_q <= name_cnt_q + 1'b1;
							end
						end else if (cmd.cls == CLS_SEP) begin
							phase_q <= PH_PARAMS;
						end else begin
							phase_q <= PH_IDLE;
						end
					end
					PH_PARAMS: begin
						if (cmd.cls == CLS_EOL) begin
							pending_q <= 1'b1;
							phase_q   <= PH_IDLE;
						end else if (arg_wr) begin
							arg_cnt_q <= arg_cnt_q + 1'b1;
						end
					end
					default: phase_q <= PH_IDLE;
				endcase
			end
		end
	end

	// Name letters: each entry loads when the count points at it
	always_ff @(posedge clk) begin
		for (int i = 0; i < NameCap; i++) begin
			if (name_wr && (name_cnt_q == NCW'(i))) begin
				name_q[i] <= cmd.data;
			end
		end
	end

	hcfp_ram #(
		.W     (8),
		.DEPTH (ArgCap)
	) u_arg_ram (
		.clk   (clk),
		.we    (arg_wr),
		.waddr (arg_cnt_q[AAW-1:0]),
		.wdata (cmd.data),
		.raddr (idx_w[AAW-1:0]),
		.rdata (ram_rdata)
	);

	// Result is built from the state left by the item now in stage 2
	assign name_cnt_ext = (NCW + 3)'(name_cnt_q);
	assign arg_cnt_ext  = (ACW + 6)'(arg_cnt_q);

	assign res_push           = valid_s2;
	assign res.frame_ready    = pending_q;
	assign res.command_length = name_cnt_ext[2:0];
	assign res.param_length   = arg_cnt_ext[5:0];
	assign res.read_data      = rd_hit_s2 ? ram_rdata : 8'd0;

	for (genvar g = 0; g < TextChars; g++) begin : g_text
		if (g < NameCap) begin : g_used
			assign res.command_text[8*g +: 8] =
				(NCW'(g) < name_cnt_q) ? name_q[g] : 8'd0;
		end else begin : g_zero
			assign res.command_text[8*g +: 8] = 8'd0;
		end
	end

endmodule

// ===== rtl/host_command_frame_parser_top.sv =====
// Top level of the host command frame parser: front end, back end, result queue.
// Path: an accepted item goes through the command queue, the back-end update, then the
//   result queue write, and shows on the outputs (empty low); it waits while no slot is free.
// Throughput: one item per cycle sustained; the back end issues one command a cycle
//   while the four-entry result queue has a free slot counting the one in flight.
// Reset: arst_n clears the parser phase, pending flag, counts and both queues;
//   name and parameter stores are not cleared and are only shown below the counts.
module host_command_frame_parser_top
	import hcfp_pkg::*;
#(
	parameter int NAME_BUF_LEN = NameBufLenDef,
	parameter int ARG_BUF_LEN  = ArgBufLenDef
) (
	input  logic             clk,
	input  logic             arst_n,
	// input side: transfer on push && !full
	input  logic             push,
	output logic             full,
	input  logic [1:0]       action,
	input  logic [7:0]       rx_byte,
	input  logic [5:0]       read_index,
	// result side: transfer on pop && !empty
	output logic             empty,
	input  logic             pop,
	output logic             frame_ready,
	output logic [TextW-1:0] command_text,
	output logic [2:0]       command_length,
	output logic [5:0]       param_length,
	output logic [7:0]       read_data
);

	localparam int RLW = $clog2(ResqDepth + 1);

	cmd_t           cmd;
	logic           cmd_empty;
	logic           cmd_pop;
	logic           res_push;
	logic           res_full;
	res_t           res_in;
	res_t           res_out;
	logic [RLW-1:0] res_level;

	// Front: classify the action and byte, hold up to two commands
	hcfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.rx_byte   (rx_byte),
		.read_index(read_index),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd       (cmd)
	);

	// Back: run the frame state machine, stores and parameter reads
	hcfp_back #(
		.NAME_BUF_LEN(NAME_BUF_LEN),
		.ARG_BUF_LEN (ARG_BUF_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_level(res_level),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue decouples the consumer from the back end
	hcfp_fifo #(
		.W     ($bits(res_t)),
		.DEPTH (ResqDepth)
	) u_resq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.din   (res_in),
		.full  (res_full),
		.pop   (pop),
		.dout  (res_out),
		.empty (empty),
		.level (res_level)
	);

	assign frame_ready    = res_out.frame_ready;
	assign command_text   = res_out.command_text;
	assign command_length = res_out.command_length;
	assign param_length   = res_out.param_length;
	assign read_data      = res_out.read_data;

	// Credit check: the back end never pushes into a full result queue
	a_res_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	// Every issued command yields exactly one result in the following cycle
	a_issue_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> res_push)
		else $error("issued command produced no result");

	a_result_from_issue: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> $past(cmd_pop))
		else $error("result without an issued command");

	// An accepted transfer always lands in the command queue
	a_accept_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> !cmd_empty)
		else $error("accepted item missing from command queue");

endmodule
